>>> rtl/ndfps_pkg.sv
`default_nettype none

package ndfps_pkg;

  // Cathodes per tube: ten digits and the comma
  localparam int unsigned CATHS     = 11;
  localparam int unsigned COMMA_IDX = 10;
  localparam int unsigned MODE_W    = 18;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned CFG_W     = 18;

  // Function codes
  localparam logic [2:0] FUNC_SET    = 3'd0;
  localparam logic [2:0] FUNC_BLANK  = 3'd1;
  localparam logic [2:0] FUNC_LEVEL  = 3'd2;
  localparam logic [2:0] FUNC_COMMA  = 3'd3;
  localparam logic [2:0] FUNC_EFFECT = 3'd4;
  localparam logic [2:0] FUNC_SCAN   = 3'd5;

  // Transition modes
  localparam logic [2:0] MODE_INSTANT = 3'd0;
  localparam logic [2:0] MODE_TWO     = 3'd2;
  localparam logic [2:0] MODE_FPREV   = 3'd4;
  localparam logic [2:0] MODE_SEQ     = 3'd5;

  // Configuration register indexes
  localparam logic CFG_MODES = 1'b0;
  localparam logic CFG_HOLD  = 1'b1;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] tube;
    logic [3:0] digit;
    logic [5:0] level;
    logic       comma_on;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cathode_mask;
    logic [2:0]  scan_tube;
    logic        anode_on;
    logic        slot_end;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/nixie_digit_fade_pwm_scanner.sv
`default_nettype none

// Six-tube multiplexed nixie driver with digit transition effects.
// Input channel (in_valid_i/in_ready_o, in_item_i) carries one operation per
// item: set digit, blank, set level, comma, effect tick or scan tick.
// Only a scan tick gives a result item on the output channel
// (out_valid_o/out_ready_i, out_item_o): cathode mask of the scanned tube.
// Cathode levels live in one synchronous RAM (TUBES*11 entries, one read and
// one write port); an item that uses the RAM walks it one entry per cycle.
// Work per item: level and comma finish on acceptance; set digit writes up
// to three entries (fade modes) or sweeps the ten digit entries (instant);
// effect tick reads and writes two entries per busy tube; scan tick reads 11.
// Items are taken one at a time; in_ready_o is high while the sequencer idles.
// A finished scan result sits in the output register; other items are taken
// meanwhile, a further scan tick waits at its last step until the register
// frees. Reset clears all cathode levels (per-entry valid bits), sets tube
// levels to MAX_LEVEL-1, digits to 0, previous digits to 9, modes 0, hold 300.
// Configuration must be written while idle; the block does not enforce it.
module nixie_digit_fade_pwm_scanner #(
  parameter int unsigned MAX_LEVEL = 60,
  parameter int unsigned TUBES     = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  ndfps_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output ndfps_pkg::out_item_t  out_item_o,
  input  wire                   cfg_we_i,
  input  wire                   cfg_idx_i,
  input  wire [ndfps_pkg::CFG_W-1:0] cfg_wdata_i
);
  import ndfps_pkg::*;

  localparam int unsigned DEPTH = TUBES * CATHS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TIW   = (TUBES > 1) ? $clog2(TUBES) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_WR3   = 4'd2;
  localparam logic [3:0] S_ESEL  = 4'd3;
  localparam logic [3:0] S_ERP   = 4'd4;
  localparam logic [3:0] S_ERC   = 4'd5;
  localparam logic [3:0] S_ECMP  = 4'd6;
  localparam logic [3:0] S_EWC   = 4'd7;
  localparam logic [3:0] S_SRD   = 4'd8;
  localparam logic [3:0] S_SOUT  = 4'd9;

  logic [3:0]        state_q;
  logic [MODE_W-1:0] modes_q;
  logic [HOLD_W-1:0] hold_q;
  logic [5:0]        tlvl_q  [TUBES];
  logic [3:0]        cur_q   [TUBES];
  logic [3:0]        prev_q  [TUBES];
  logic [15:0]       timer_q [TUBES];
  logic [3:0]        r15_q   [TUBES];
  logic [2:0]        r7_q    [TUBES];
  logic [TUBES-1:0]  busy_q;
  logic [5:0]        ramp_q;
  logic [TIW-1:0]    scan_q;
  logic [TIW:0]      ecnt_q;
  logic [TIW-1:0]    op_tube_q;
  logic [3:0]        op_d_q, op_prev_q, op_cur_q;
  logic [5:0]        op_l_q;
  logic              op_both_q;
  logic [3:0]        k_q;
  logic [5:0]        lvp_q, lvc_q;
  logic [10:0]       mask_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // Cathode level RAM with per-entry valid bits for reset
  logic [5:0]        mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [5:0]        rdata_q;
  logic              rvalid_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [5:0]        mem_wdata;
  logic [5:0]        rlv;

  // Input decode
  logic              accept;
  logic              tube_ok;
  logic [TIW-1:0]    in_t;
  logic [2:0]        in_mode;
  logic [23:0]       modes_ext;
  logic [3:0]        in_cur;
  logic [5:0]        in_l;
  logic              do_set;
  logic [3:0]        set_d;
  logic [5:0]        set_l;
  logic [AW-1:0]     in_base, op_base, e_base;
  logic [TIW-1:0]    e_t;
  logic [2:0]        e_mode;

  // Effect step
  logic [15:0]       tn;
  logic [3:0]        r15n;
  logic [2:0]        r7n;
  logic [5:0]        p_new, c_new, e_l;
  logic              e_done;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign tube_ok    = (32'(in_item_i.tube) < TUBES);
  assign in_t       = in_item_i.tube[TIW-1:0];
  assign modes_ext  = {6'b0, modes_q};
  assign in_mode    = modes_ext[3*in_item_i.tube +: 3];
  assign in_cur     = cur_q[in_t];
  assign in_l       = tlvl_q[in_t];
  assign in_base    = AW'(in_t) * AW'(CATHS);
  assign op_base    = AW'(op_tube_q) * AW'(CATHS);
  assign e_t        = ecnt_q[TIW-1:0];
  assign e_base     = AW'(e_t) * AW'(CATHS);
  assign e_mode     = modes_ext[3*(3'(e_t)) +: 3];
  assign e_l        = tlvl_q[e_t];
  assign rlv        = rvalid_q ? rdata_q : 6'd0;

  // Pick the digit write for set and blank
  always_comb begin
    do_set = 1'b0;
    set_d  = in_item_i.digit;
    set_l  = in_l;
    if (tube_ok && in_item_i.func == FUNC_SET && in_item_i.digit <= 4'd9) begin
      do_set = 1'b1;
    end else if (tube_ok && in_item_i.func == FUNC_BLANK) begin
      do_set = 1'b1;
      set_d  = in_cur;
      set_l  = 6'd0;
    end
  end

  // Advance one busy tube by one effect tick
  always_comb begin
    tn     = timer_q[e_t] + 16'd1;
    r15n   = (tn == 16'd0 || r15_q[e_t] == 4'd14) ? 4'd0 : r15_q[e_t] + 4'd1;
    r7n    = (tn == 16'd0 || r7_q[e_t] == 3'd6) ? 3'd0 : r7_q[e_t] + 3'd1;
    p_new  = lvp_q;
    c_new  = rlv;
    e_done = 1'b0;
    unique case (e_mode)
      MODE_TWO: begin
        if (tn >= hold_q) begin
          p_new  = 6'd0;
          e_done = 1'b1;
        end
      end
      MODE_FPREV: begin
        if (r15n == 4'd0) begin
          if (lvp_q != 6'd0) p_new = lvp_q - 6'd1;
          c_new  = e_l;
          e_done = (lvp_q == 6'd0);
        end
      end
      MODE_SEQ: begin
        if (r7n == 3'd0) begin
          if (lvp_q != 6'd0) begin
            p_new = lvp_q - 6'd1;
          end else if (rlv < e_l) begin
            c_new = rlv + 6'd1;
          end else begin
            e_done = 1'b1;
          end
        end
      end
      default: begin
        if (r15n == 4'd0) begin
          if (lvp_q != 6'd0) p_new = lvp_q - 6'd1;
          if (rlv < e_l) c_new = rlv + 6'd1;
          e_done = (lvp_q == 6'd0) && (rlv >= e_l);
        end
      end
    endcase
  end

  // Steer the RAM ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_base;
    mem_wdata = 6'd0;
    mem_raddr = op_base;
    unique case (state_q)
      S_IDLE: begin
        if (accept && tube_ok && in_item_i.func == FUNC_COMMA) begin
          mem_we    = 1'b1;
          mem_waddr = in_base + AW'(COMMA_IDX);
          mem_wdata = in_item_i.comma_on ? in_l : 6'd0;
        end else if (accept && do_set && in_mode != MODE_INSTANT && in_cur == set_d) begin
          mem_we    = 1'b1;
          mem_waddr = in_base + AW'(in_cur);
          mem_wdata = set_l;
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = op_base + AW'(k_q);
        mem_wdata = (k_q == op_d_q && k_q != op_prev_q) ? op_l_q : 6'd0;
      end
      S_WR3: begin
        priority case (k_q)
          4'd0: begin
            mem_we    = (op_prev_q <= 4'd9);
            mem_waddr = op_base + AW'(op_prev_q);
          end
          4'd1: begin
            mem_we    = op_both_q;
            mem_waddr = op_base + AW'(op_d_q);
            mem_wdata = op_l_q;
          end
          default: begin
            mem_we    = op_both_q;
            mem_waddr = op_base + AW'(op_cur_q);
            mem_wdata = op_l_q;
          end
        endcase
      end
      S_ERP: mem_raddr = e_base + AW'(prev_q[e_t]);
      S_ERC: mem_raddr = e_base + AW'(cur_q[e_t]);
      S_ECMP: begin
        mem_we    = 1'b1;
        mem_waddr = e_base + AW'(prev_q[e_t]);
        mem_wdata = p_new;
      end
      S_EWC: begin
        mem_we    = 1'b1;
        mem_waddr = e_base + AW'(cur_q[e_t]);
        mem_wdata = lvc_q;
      end
      S_SRD: begin
        if (k_q < 4'(CATHS)) mem_raddr = op_base + AW'(k_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[mem_raddr];
      if (mem_we) valid_q[mem_waddr] <= 1'b1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q <= '0;
      hold_q  <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODES: modes_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_HOLD:  hold_q  <= cfg_wdata_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and per-tube state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      ramp_q      <= '0;
      scan_q      <= '0;
      ecnt_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TUBES; i++) begin
        tlvl_q[i]  <= 6'(MAX_LEVEL - 1);
        cur_q[i]   <= 4'd0;
        prev_q[i]  <= 4'd9;
        timer_q[i] <= 16'd0;
        r15_q[i]   <= 4'd0;
        r7_q[i]    <= 3'd0;
      end
    end else begin
      // Drop the result once taken, unless a new one loads this cycle
      if (out_valid_q && out_ready_i && state_q != S_SOUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_tube_q <= (in_item_i.func == FUNC_SCAN) ? scan_q : in_t;
            k_q       <= 4'd0;
            if (tube_ok && in_item_i.func == FUNC_BLANK) tlvl_q[in_t] <= 6'd0;
            if (tube_ok && in_item_i.func == FUNC_LEVEL) tlvl_q[in_t] <= in_item_i.level;
            if (do_set) begin
              op_d_q    <= set_d;
              op_l_q    <= set_l;
              op_cur_q  <= in_cur;
              op_both_q <= (in_mode == MODE_TWO);
              if (in_mode == MODE_INSTANT) begin
                cur_q[in_t] <= set_d;
                if (in_cur != set_d) begin
                  prev_q[in_t] <= in_cur;
                  op_prev_q    <= in_cur;
                end else begin
                  op_prev_q    <= prev_q[in_t];
                end
                state_q <= S_CLR;
              end else if (in_cur != set_d) begin
                op_prev_q     <= prev_q[in_t];
                prev_q[in_t]  <= in_cur;
                cur_q[in_t]   <= set_d;
                timer_q[in_t] <= 16'd0;
                r15_q[in_t]   <= 4'd0;
                r7_q[in_t]    <= 3'd0;
                busy_q[in_t]  <= 1'b1;
                state_q       <= S_WR3;
              end
            end
            if (in_item_i.func == FUNC_EFFECT) begin
              ecnt_q  <= '0;
              state_q <= S_ESEL;
            end
            if (in_item_i.func == FUNC_SCAN) begin
              state_q   <= S_SRD;
            end
          end
        end
        S_CLR: begin
          k_q <= k_q + 4'd1;
          if (k_q == 4'd9) state_q <= S_IDLE;
        end
        S_WR3: begin
          k_q <= k_q + 4'd1;
          if (k_q == 4'd2) state_q <= S_IDLE;
        end
        S_ESEL: begin
          if (32'(ecnt_q) >= TUBES) begin
            state_q <= S_IDLE;
          end else if (busy_q[e_t]) begin
            state_q <= S_ERP;
          end else begin
            ecnt_q <= ecnt_q + 1'b1;
          end
        end
        S_ERP: state_q <= S_ERC;
        S_ERC: begin
          lvp_q   <= rlv;
          state_q <= S_ECMP;
        end
        S_ECMP: begin
          lvc_q       <= c_new;
          timer_q[e_t] <= tn;
          r15_q[e_t]  <= r15n;
          r7_q[e_t]   <= r7n;
          if (e_done) busy_q[e_t] <= 1'b0;
          state_q     <= S_EWC;
        end
        S_EWC: begin
          ecnt_q  <= ecnt_q + 1'b1;
          state_q <= S_ESEL;
        end
        S_SRD: begin
          k_q <= k_q + 4'd1;
          if (k_q != 4'd0) mask_q <= {(rlv > ramp_q), mask_q[10:1]};
          if (k_q == 4'(CATHS)) state_q <= S_SOUT;
        end
        S_SOUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q        <= 1'b1;
            out_q.cathode_mask <= mask_q;
            out_q.scan_tube    <= 3'(scan_q);
            out_q.anode_on     <= (mask_q != 11'd0);
            out_q.slot_end     <= (32'(ramp_q) >= MAX_LEVEL);
            if (32'(ramp_q) >= MAX_LEVEL) begin
              ramp_q <= 6'd0;
              scan_q <= (32'(scan_q) + 1 >= TUBES) ? '0 : scan_q + 1'b1;
            end else begin
              ramp_q <= ramp_q + 6'd1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Ramp never passes its top
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(ramp_q) <= MAX_LEVEL)
    else $error("pwm ramp beyond maximum");
  // Tube 0's current and previous digit never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni) prev_q[0] != cur_q[0])
    else $error("tube 0 digits coincide");
  // A transition on tube 0 starts with a cleared timer
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(busy_q[0]) |-> timer_q[0] == 16'd0)
    else $error("transition started with running timer");
  // A result names a tube that exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 32'(out_q.scan_tube) < TUBES)
    else $error("scan tube out of range");

endmodule

`default_nettype wire

>>> tb/tb_nixie_digit_fade_pwm_scanner.sv
`default_nettype none

module tb_nixie_digit_fade_pwm_scanner;
  import ndfps_pkg::*;

  localparam int unsigned MAX_LEVEL = 60;
  localparam int unsigned TUBES     = 6;
  localparam logic [2:0]  MODE_FADE = 3'd3;
  localparam logic [2:0]  MODE_ODD  = 3'd7;
  localparam logic [2:0]  FUNC_NOP6 = 3'd6;
  localparam logic [2:0]  FUNC_NOP7 = 3'd7;
  localparam int          CYCLE_LIMIT = 800000;
  localparam int          DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  nixie_digit_fade_pwm_scanner #(.MAX_LEVEL(MAX_LEVEL), .TUBES(TUBES)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Clock: period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted tube state
  logic [5:0]  cath_lvl [TUBES][CATHS];
  logic [5:0]  tube_lvl [TUBES];
  logic [3:0]  cur_dig [TUBES];
  logic [3:0]  prev_dig [TUBES];
  logic [15:0] fade_tmr [TUBES];
  logic [TUBES-1:0] busy;
  logic [5:0]  ramp;
  logic [2:0]  scan_pos;
  logic [17:0] mode_reg;
  logic [15:0] hold_reg;

  in_item_t  pending_ops [$];
  out_item_t expected_masks [$];
  int errors = 0;
  int ops_taken = 0;
  int masks_seen = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit quiet = 1'b0;
  bit op_taken = 1'b0;

  function automatic logic [2:0] mode_of(int t);
    return mode_reg[3*t +: 3];
  endfunction

  task automatic begin_fade(int t, logic [3:0] d, bit light_both);
    logic [3:0] old_prev;
    logic [3:0] c;
    old_prev = prev_dig[t];
    c = cur_dig[t];
    if (c == d) begin
      cath_lvl[t][c] = tube_lvl[t];
      return;
    end
    prev_dig[t] = c;
    if (old_prev < 10) cath_lvl[t][old_prev] = '0;
    cur_dig[t] = d;
    if (light_both) begin
      cath_lvl[t][d] = tube_lvl[t];
      cath_lvl[t][c] = tube_lvl[t];
    end
    fade_tmr[t] = '0;
    busy[t] = 1'b1;
  endtask

  task automatic show_digit(int t, logic [3:0] d);
    logic [2:0] m;
    m = mode_of(t);
    if (m == MODE_INSTANT) begin
      if (cur_dig[t] != d) prev_dig[t] = cur_dig[t];
      cur_dig[t] = d;
      for (int i = 0; i < 10; i++) cath_lvl[t][i] = '0;
      cath_lvl[t][d] = tube_lvl[t];
      if (prev_dig[t] < 10) cath_lvl[t][prev_dig[t]] = '0;
    end else begin
      begin_fade(t, d, m == MODE_TWO);
    end
  endtask

  task automatic advance_tube(int t);
    logic [2:0] m;
    int p, c;
    logic [5:0] lvl;
    bit done_p, done_c;
    m = mode_of(t);
    p = prev_dig[t] % 10;
    c = cur_dig[t] % 10;
    lvl = tube_lvl[t];
    done_p = 1'b0;
    done_c = 1'b0;
    fade_tmr[t] = fade_tmr[t] + 16'd1;
    if (m == MODE_TWO) begin
      if (fade_tmr[t] >= hold_reg) begin
        cath_lvl[t][p] = '0;
        done_p = 1'b1;
        done_c = 1'b1;
      end
    end else if (m == MODE_FPREV) begin
      if (fade_tmr[t] % 15 == 0) begin
        if (cath_lvl[t][p] > 0) cath_lvl[t][p]--; else done_p = 1'b1;
        cath_lvl[t][c] = lvl;
        done_c = 1'b1;
      end
    end else if (m == MODE_SEQ) begin
      if (fade_tmr[t] % 7 == 0) begin
        if (cath_lvl[t][p] > 0) begin
          cath_lvl[t][p]--;
        end else begin
          done_p = 1'b1;
          if (cath_lvl[t][c] < lvl) cath_lvl[t][c]++; else done_c = 1'b1;
        end
      end
    end else begin
      // instant and unsupported codes step as a cross-fade
      if (fade_tmr[t] % 15 == 0) begin
        if (cath_lvl[t][p] > 0) cath_lvl[t][p]--; else done_p = 1'b1;
        if (cath_lvl[t][c] < lvl) cath_lvl[t][c]++; else done_c = 1'b1;
      end
    end
    if (done_p && done_c) busy[t] = 1'b0;
  endtask

  // Apply one accepted operation and queue the mask a scan tick produces
  task automatic apply_op(in_item_t op);
    int t, s;
    out_item_t r;
    t = op.tube;
    if (op.func <= FUNC_COMMA) begin
      if (t >= TUBES) return;
      case (op.func)
        FUNC_SET: if (op.digit <= 9) show_digit(t, op.digit);
        FUNC_BLANK: begin
          tube_lvl[t] = '0;
          show_digit(t, cur_dig[t] % 10);
        end
        FUNC_LEVEL: tube_lvl[t] = op.level;
        default: cath_lvl[t][COMMA_IDX] = op.comma_on ? tube_lvl[t] : 6'd0;
      endcase
    end else if (op.func == FUNC_EFFECT) begin
      for (int i = 0; i < TUBES; i++) if (busy[i]) advance_tube(i);
    end else if (op.func == FUNC_SCAN) begin
      s = (scan_pos >= TUBES) ? 0 : scan_pos;
      r = '0;
      for (int i = 0; i < CATHS; i++) r.cathode_mask[i] = cath_lvl[s][i] > ramp;
      r.scan_tube = s;
      r.anode_on = r.cathode_mask != 0;
      if (ramp >= MAX_LEVEL) begin
        ramp = '0;
        r.slot_end = 1'b1;
        scan_pos = (s + 1 >= TUBES) ? 0 : s + 1;
      end else begin
        ramp = ramp + 6'd1;
      end
      expected_masks.push_back(r);
    end
  endtask

  function automatic in_item_t make_op(logic [2:0] f, int t, int d, int lvl, bit c);
    in_item_t op;
    op.func = f;
    op.tube = t;
    op.digit = d;
    op.level = lvl;
    op.comma_on = c;
    return op;
  endfunction

  // Random operation, weighted toward ticks so fades make progress
  function automatic in_item_t random_op();
    int w;
    logic [2:0] f;
    w = $urandom_range(0, 99);
    if (w < 35) f = FUNC_SCAN;
    else if (w < 65) f = FUNC_EFFECT;
    else if (w < 82) f = FUNC_SET;
    else if (w < 87) f = FUNC_BLANK;
    else if (w < 92) f = FUNC_LEVEL;
    else if (w < 97) f = FUNC_COMMA;
    else f = $urandom_range(0, 1) ? FUNC_NOP6 : FUNC_NOP7;
    return make_op(f, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 5),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9),
                   $urandom_range(0, 63), $urandom_range(0, 1));
  endfunction

  // Drive input items at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !op_taken) begin
        // hold until accepted
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_ops.size() > 0) begin
        in_item_i <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 17);
      end else begin
        in_valid_i <= 1'b0;
      end
      // stall the result side in bursts
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) out_stall <= $urandom_range(1, 17);
      end
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    out_item_t want;
    cycles <= cycles + 1;
    op_taken <= in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      masks_seen <= masks_seen + 1;
      if (expected_masks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        errors <= errors + 1;
      end else begin
        want = expected_masks.pop_front();
        if (out_item_o.cathode_mask !== want.cathode_mask ||
            out_item_o.scan_tube !== want.scan_tube ||
            out_item_o.anode_on !== want.anode_on ||
            out_item_o.slot_end !== want.slot_end) begin
          $display("%0t: mismatch expected mask=%h tube=%0d anode=%b end=%b, got mask=%h tube=%0d anode=%b end=%b",
                   $time, want.cathode_mask, want.scan_tube, want.anode_on, want.slot_end,
                   out_item_o.cathode_mask, out_item_o.scan_tube, out_item_o.anode_on,
                   out_item_o.slot_end);
          errors <= errors + 1;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      ops_taken <= ops_taken + 1;
      apply_op(in_item_i);
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODES) mode_reg = val[17:0];
    else hold_reg = val[15:0];
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid_i || expected_masks.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [17:0] modes_set [6];
    logic [15:0] holds_set [6];
    for (int t = 0; t < TUBES; t++) begin
      for (int i = 0; i < CATHS; i++) cath_lvl[t][i] = '0;
      tube_lvl[t] = MAX_LEVEL - 1;
      cur_dig[t] = '0;
      prev_dig[t] = 4'd9;
      fade_tmr[t] = '0;
    end
    busy = '0;
    ramp = '0;
    scan_pos = '0;
    mode_reg = '0;
    hold_reg = 16'd300;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    // Directed: one tube per mode, short hold
    write_reg(CFG_MODES, {MODE_ODD, MODE_SEQ, MODE_FPREV, MODE_FADE, MODE_TWO, MODE_INSTANT});
    write_reg(CFG_HOLD, 18'd1);
    for (int t = 0; t < TUBES; t++) pending_ops.push_back(make_op(FUNC_SET, t, 9, 0, 0));
    pending_ops.push_back(make_op(FUNC_SET, 0, 15, 0, 1));
    pending_ops.push_back(make_op(FUNC_SET, 7, 3, 63, 1));
    pending_ops.push_back(make_op(FUNC_LEVEL, 0, 0, 63, 0));
    pending_ops.push_back(make_op(FUNC_COMMA, 0, 0, 0, 1));
    pending_ops.push_back(make_op(FUNC_COMMA, 2, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_BLANK, 1, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_NOP6, 0, 0, 0, 0));
    pending_ops.push_back(make_op(FUNC_NOP7, 7, 15, 63, 1));
    pending_ops.push_back(make_op(FUNC_SET, 0, 0, 0, 0));
    repeat (3) pending_ops.push_back(make_op(FUNC_EFFECT, 0, 0, 0, 0));
    repeat (6) pending_ops.push_back(make_op(FUNC_SCAN, 0, 0, 0, 0));
    drain();

    // Random phases, each under its own register setting
    modes_set = '{18'h3FFFF, 18'h00000, 18'h2DB6D, 18'h1B6DB, 18'h12492, 18'h0B6DA};
    holds_set = '{16'd1, 16'hFFFF, 16'd2, 16'd300, 16'd20, 16'd1};
    modes_set[2] = $urandom_range(0, 18'h3FFFF);
    holds_set[4] = $urandom_range(1, 40);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MODES, modes_set[ph]);
      write_reg(CFG_HOLD, holds_set[ph]);
      if (ph == 5) quiet = 1'b1;
      repeat (190) pending_ops.push_back(random_op());
      drain();
    end

    $display("Covered %0d input items and %0d scan results over seven register settings.",
             ops_taken, masks_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> nixie_digit_fade_pwm_scanner.f
rtl/ndfps_pkg.sv
rtl/nixie_digit_fade_pwm_scanner.sv
tb/tb_nixie_digit_fade_pwm_scanner.sv
